// ----- design/fqs_pkg.sv -----
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the bounded FIFO queue with membership search.
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int DEPTH     = 16;
    localparam int PAYLOAD_W = 32;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OCC_W     = 5;

    // command codes
    localparam logic [1:0] CMD_ENQ    = 2'd0;
    localparam logic [1:0] CMD_DEQ    = 2'd1;
    localparam logic [1:0] CMD_EXISTS = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [PAYLOAD_W-1:0] item_data;
    } t_in_item;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] out_payload;
        logic [1:0]           status;
        logic                 found;
        logic [PAYLOAD_W-1:0] head_payload;
        logic                 head_valid;
        logic [OCC_W-1:0]     occupancy;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_SCAN,
        S_PEEK,
        S_DONE
    } t_state;

endpackage

// ----- design/fifo_queue_with_search.sv -----
// Sequence: an accepted beat steps through S_OP, then S_SCAN for exists only, then
//   S_PEEK and S_DONE; exists reads and compares the queued entries from the head
//   until a hit or until every queued entry is compared.
// Flow: one item at a time; the next input beat is taken once the result is
//   loaded; a held result stalls it.
// Reset: synchronous, active low; queue empty, no result pending, store not cleared.
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// Circular-buffer FIFO of payload handles with enqueue, dequeue and a
// sequential membership search over the queued entries.
// ----------------------------------------------------------------------------
module fifo_queue_with_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fqs_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output fqs_pkg::t_out_item o_data
);

    localparam logic [fqs_pkg::ADDR_W-1:0] LAST_SLOT = fqs_pkg::ADDR_W'(fqs_pkg::DEPTH - 1);
    localparam logic [fqs_pkg::CNT_W-1:0]  FULL_CNT  = fqs_pkg::CNT_W'(fqs_pkg::DEPTH);

    function automatic logic [fqs_pkg::ADDR_W-1:0] next_slot(
        input logic [fqs_pkg::ADDR_W-1:0] idx
    );
        next_slot = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    fqs_pkg::t_state r_state, n_state;

    logic [1:0]                   r_cmd;
    logic [fqs_pkg::PAYLOAD_W-1:0] r_query;
    logic [fqs_pkg::ADDR_W-1:0]   r_head, n_head;
    logic [fqs_pkg::ADDR_W-1:0]   r_tail, n_tail;
    logic [fqs_pkg::CNT_W-1:0]    r_count, n_count;
    logic [fqs_pkg::ADDR_W-1:0]   r_scan_pos, n_scan_pos;
    logic [fqs_pkg::CNT_W-1:0]    r_scan_k, n_scan_k;
    logic                         r_cmp_vld, n_cmp_vld;
    logic                         r_found, n_found;
    logic [fqs_pkg::PAYLOAD_W-1:0] r_payload, n_payload;
    logic [1:0]                   r_status, n_status;

    logic [fqs_pkg::PAYLOAD_W-1:0] r_mem [fqs_pkg::DEPTH];
    logic [fqs_pkg::PAYLOAD_W-1:0] r_rd_data;
    logic [fqs_pkg::ADDR_W-1:0]   rd_addr;
    logic                         mem_we;

    fqs_pkg::t_out_item           r_out, n_out;
    logic                         r_out_vld, n_out_vld;

    logic in_fire;
    logic scan_issue;
    logic scan_hit;
    logic scan_done;
    logic out_load;

    assign o_ready   = (r_state == fqs_pkg::S_IDLE);
    assign in_fire   = i_valid && o_ready;
    assign scan_issue = (r_scan_k < r_count);
    assign scan_hit  = r_cmp_vld && (r_rd_data == r_query);
    assign scan_done = scan_hit || (!scan_issue && !r_cmp_vld);
    assign out_load  = (r_state == fqs_pkg::S_DONE) && (!r_out_vld || i_ready);
    assign mem_we    = (r_state == fqs_pkg::S_OP) && (r_cmd == fqs_pkg::CMD_ENQ)
                       && (r_count != FULL_CNT);
    assign rd_addr   = (r_state == fqs_pkg::S_SCAN) ? r_scan_pos : r_head;

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fqs_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_state = fqs_pkg::S_OP;
                end
            end
            fqs_pkg::S_OP: begin
                n_state = (r_cmd == fqs_pkg::CMD_EXISTS) ? fqs_pkg::S_SCAN : fqs_pkg::S_PEEK;
            end
            fqs_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = fqs_pkg::S_PEEK;
                end
            end
            fqs_pkg::S_PEEK: begin
                n_state = fqs_pkg::S_DONE;
            end
            fqs_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = fqs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fqs_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_scan_pos = r_scan_pos;
        n_scan_k   = r_scan_k;
        n_cmp_vld  = r_cmp_vld;
        n_found    = r_found;
        n_payload  = r_payload;
        n_status   = r_status;
        n_out      = r_out;
        n_out_vld  = r_out_vld;

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            fqs_pkg::S_IDLE: begin
                n_found   = 1'b0;
                n_payload = '0;
                n_status  = fqs_pkg::STS_OK;
            end
            fqs_pkg::S_OP: begin
                case (r_cmd)
                    fqs_pkg::CMD_ENQ: begin
                        if (r_count == FULL_CNT) begin
                            n_status = fqs_pkg::STS_FULL;
                        end else begin
                            n_tail  = next_slot(r_tail);
                            n_count = r_count + 1'b1;
                        end
                    end
                    fqs_pkg::CMD_DEQ: begin
                        if (r_count == '0) begin
                            n_status = fqs_pkg::STS_EMPTY;
                        end else begin
                            // head entry was read during the input beat
                            n_payload = r_rd_data;
                            n_head    = next_slot(r_head);
                            n_count   = r_count - 1'b1;
                        end
                    end
                    fqs_pkg::CMD_EXISTS: begin
                        n_scan_pos = r_head;
                        n_scan_k   = '0;
                        n_cmp_vld  = 1'b0;
                    end
                    default: begin
                        n_status = fqs_pkg::STS_OK;
                    end
                endcase
            end
            fqs_pkg::S_SCAN: begin
                // issue one read per cycle, compare the previous one
                if (scan_hit) begin
                    n_found = 1'b1;
                end
                n_cmp_vld = scan_issue && !scan_hit;
                if (scan_issue) begin
                    n_scan_pos = next_slot(r_scan_pos);
                    n_scan_k   = r_scan_k + 1'b1;
                end
            end
            fqs_pkg::S_PEEK: begin
                n_cmp_vld = 1'b0;
            end
            fqs_pkg::S_DONE: begin
                if (out_load) begin
                    n_out_vld          = 1'b1;
                    n_out.out_payload  = r_payload;
                    n_out.status       = r_status;
                    n_out.found        = r_found;
                    n_out.head_valid   = (r_count != '0);
                    n_out.head_payload = (r_count != '0) ? r_rd_data : '0;
                    n_out.occupancy    = fqs_pkg::OCC_W'(r_count);
                end
            end
            default: begin
                n_cmp_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fqs_pkg::S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd   <= i_data.cmd;
            r_query <= i_data.item_data;
        end
        r_scan_pos <= n_scan_pos;
        r_scan_k   <= n_scan_k;
        r_found    <= n_found;
        r_payload  <= n_payload;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= r_query;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("occupancy exceeds queue depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) == ((r_count == '0) || (r_count == FULL_CNT)))
        else $error("head/tail pointers disagree with occupancy");

    a_accept_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == fqs_pkg::S_OP))
        else $error("accepted beat did not start an operation");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status == fqs_pkg::STS_EMPTY))
        |-> (!r_out.head_valid && (r_out.occupancy == '0)))
        else $error("empty status with nonempty queue");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status == fqs_pkg::STS_FULL))
        |-> (r_out.occupancy == fqs_pkg::OCC_W'(fqs_pkg::DEPTH)))
        else $error("full status with queue not full");

endmodule
